@@ src/mrrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrrc_pkg
// shared types, codes and the crc-16 byte update for the response checker
// ----------------------------------------------------------------------------
package mrrc_pkg;

	localparam int unsigned MaxReadWords = 125;

	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;
	localparam logic [7:0]  ExcMask = 8'h80;

	localparam logic [7:0] FN_READ_HOLDING = 8'h03;
	localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
	localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;

	typedef enum logic [1:0] {
		CFG_SERVER_ADDR = 2'd0,
		CFG_EXP_FUNC    = 2'd1,
		CFG_EXP_ADDR    = 2'd2,
		CFG_EXP_WORD    = 2'd3
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_SLAVE       = 4'd1,
		ST_FUNCTION    = 4'd2,
		ST_CRC         = 4'd3,
		ST_EXCEPTION   = 4'd4,
		ST_LENGTH      = 4'd5,
		ST_ADDR_ECHO   = 4'd6,
		ST_VALUE_ECHO  = 4'd7,
		ST_UNSUPPORTED = 4'd8
	} status_t;

	typedef struct packed {
		logic [7:0]  server_addr;
		logic [7:0]  expected_function;
		logic [15:0] expected_address;
		logic [15:0] expected_word;
	} cfg_t;

	typedef struct packed {
		logic        is_final;
		logic [6:0]  word_index;
		logic [15:0] word_value;
		status_t     status;
		logic [7:0]  exception_code;
	} result_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ src/mrrc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mrrc_cfg_regs
// configuration register file written through the plain write port
// ----------------------------------------------------------------------------
module mrrc_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output mrrc_pkg::cfg_t      cfg
);

	mrrc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.server_addr       <= 8'd1;
			cfg_q.expected_function <= mrrc_pkg::FN_READ_HOLDING;
			cfg_q.expected_address  <= 16'd0;
			cfg_q.expected_word     <= 16'd1;
		end else if (cfg_we) begin
			unique case (mrrc_pkg::cfg_index_t'(cfg_index))
				mrrc_pkg::CFG_SERVER_ADDR: cfg_q.server_addr       <= cfg_data[7:0];
				mrrc_pkg::CFG_EXP_FUNC:    cfg_q.expected_function <= cfg_data[7:0];
				mrrc_pkg::CFG_EXP_ADDR:    cfg_q.expected_address  <= cfg_data;
				mrrc_pkg::CFG_EXP_WORD:    cfg_q.expected_word     <= cfg_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/mrrc_frame_checker.sv @@
// ----------------------------------------------------------------------------
// mrrc_frame_checker
// per-frame state, crc update, frame checks and the result register
// ----------------------------------------------------------------------------
module mrrc_frame_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mrrc_pkg::cfg_t       cfg,
	input  logic                 valid_s1,
	input  logic [7:0]           byte_s1,
	input  logic                 start_s1,
	input  logic                 result_stall,
	output logic                 advance,
	output logic                 result_valid,
	output mrrc_pkg::result_t    result
);

	logic [8:0]  pos_q;
	logic [15:0] crc_q;
	logic [7:0]  rf_q;
	logic [7:0]  bc_q;
	logic [7:0]  held_q;
	logic [1:0]  flags_q;
	logic        closed_q;

	logic [8:0]  pos_n;
	logic [15:0] crc_n;
	logic [7:0]  rf_n;
	logic [7:0]  bc_n;
	logic [7:0]  held_n;
	logic [1:0]  flags_n;
	logic        closed_n;

	logic              res_valid_s2;
	mrrc_pkg::result_t res_s2;
	logic              produce;
	mrrc_pkg::result_t res_n;
	logic              fire;

	logic [8:0]  pos_e;
	logic [15:0] crc_e;
	logic [7:0]  rf_e;
	logic [7:0]  bc_e;
	logic [7:0]  held_e;
	logic [1:0]  flags_e;
	logic        closed_e;
	logic [8:0]  d;
	logic [7:0]  idx;
	logic [8:0]  data_end;
	logic [15:0] echo_word;

	assign advance = !res_valid_s2 || !result_stall;
	assign fire    = valid_s1 && advance;

	always_comb begin
		pos_e    = start_s1 ? 9'd0 : pos_q;
		crc_e    = start_s1 ? mrrc_pkg::CrcInit : crc_q;
		rf_e     = start_s1 ? 8'd0 : rf_q;
		bc_e     = start_s1 ? 8'd0 : bc_q;
		held_e   = start_s1 ? 8'd0 : held_q;
		flags_e  = start_s1 ? 2'd0 : flags_q;
		closed_e = start_s1 ? 1'b0 : closed_q;

		d         = pos_e - 9'd3;
		idx       = d[8:1];
		data_end  = {1'b0, bc_e} + 9'd3;
		echo_word = {held_e, byte_s1};

		pos_n    = pos_e;
		crc_n    = crc_e;
		rf_n     = rf_e;
		bc_n     = bc_e;
		held_n   = held_e;
		flags_n  = flags_e;
		closed_n = closed_e;

		produce                = 1'b0;
		res_n.is_final         = 1'b1;
		res_n.word_index       = 7'd0;
		res_n.word_value       = 16'd0;
		res_n.status           = mrrc_pkg::ST_OK;
		res_n.exception_code   = 8'd0;

		if (!closed_e) begin
			crc_n = mrrc_pkg::crc_byte(crc_e, byte_s1);
			pos_n = pos_e + 9'd1;

			if (pos_e == 9'd0) begin
				if (byte_s1 != cfg.server_addr) begin
					produce      = 1'b1;
					res_n.status = mrrc_pkg::ST_SLAVE;
				end
			end else if (pos_e == 9'd1) begin
				rf_n = byte_s1;
				if ((byte_s1 & mrrc_pkg::ExcMask) == 8'd0) begin
					if (byte_s1 != cfg.expected_function) begin
						produce      = 1'b1;
						res_n.status = mrrc_pkg::ST_FUNCTION;
					end else if (byte_s1 != mrrc_pkg::FN_READ_HOLDING &&
						byte_s1 != mrrc_pkg::FN_WRITE_SINGLE &&
						byte_s1 != mrrc_pkg::FN_WRITE_MULTI) begin
						produce      = 1'b1;
						res_n.status = mrrc_pkg::ST_UNSUPPORTED;
					end
				end
			end else if ((rf_e & mrrc_pkg::ExcMask) != 8'd0) begin
				// exception frame
				if (pos_e == 9'd2) begin
					held_n = byte_s1;
				end
				if (pos_e == 9'd4) begin
					produce = 1'b1;
					if (crc_n != 16'd0) begin
						res_n.status = mrrc_pkg::ST_CRC;
					end else begin
						res_n.status         = mrrc_pkg::ST_EXCEPTION;
						res_n.exception_code = held_e;
					end
				end
			end else if (rf_e == mrrc_pkg::FN_READ_HOLDING) begin
				if (pos_e == 9'd2) begin
					bc_n = byte_s1;
				end else if (pos_e < data_end) begin
					if (!d[0]) begin
						held_n = byte_s1;
					end else if (idx < 8'(mrrc_pkg::MaxReadWords)) begin
						produce          = 1'b1;
						res_n.is_final   = 1'b0;
						res_n.word_index = idx[6:0];
						res_n.word_value = echo_word;
					end
				end else if (pos_e == data_end + 9'd1) begin
					produce = 1'b1;
					if (crc_n != 16'd0) begin
						res_n.status = mrrc_pkg::ST_CRC;
					end else if ({9'd0, bc_e} != {cfg.expected_word, 1'b0} ||
						{1'b0, bc_e} > 9'(2 * mrrc_pkg::MaxReadWords)) begin
						res_n.status = mrrc_pkg::ST_LENGTH;
					end
				end
			end else begin
				// write single or write multiple echo
				case (pos_e)
					9'd2, 9'd4: held_n = byte_s1;
					9'd3: begin
						if (echo_word != cfg.expected_address) begin
							flags_n[0] = 1'b1;
						end
					end
					9'd5: begin
						if (echo_word != cfg.expected_word) begin
							flags_n[1] = 1'b1;
						end
					end
					9'd7: begin
						produce = 1'b1;
						if (crc_n != 16'd0) begin
							res_n.status = mrrc_pkg::ST_CRC;
						end else if (flags_e[0]) begin
							res_n.status = mrrc_pkg::ST_ADDR_ECHO;
						end else if (flags_e[1]) begin
							res_n.status = mrrc_pkg::ST_VALUE_ECHO;
						end
					end
					default: ;
				endcase
			end

			if (produce && res_n.is_final) begin
				closed_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 9'd0;
			crc_q    <= mrrc_pkg::CrcInit;
			rf_q     <= 8'd0;
			bc_q     <= 8'd0;
			held_q   <= 8'd0;
			flags_q  <= 2'd0;
			closed_q <= 1'b1;
		end else if (fire) begin
			pos_q    <= pos_n;
			crc_q    <= crc_n;
			rf_q     <= rf_n;
			bc_q     <= bc_n;
			held_q   <= held_n;
			flags_q  <= flags_n;
			closed_q <= closed_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= fire && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && produce) begin
			res_s2 <= res_n;
		end
	end

	assign result_valid = res_valid_s2;
	assign result       = res_s2;

endmodule

@@ src/modbus_rtu_response_checker_core.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_core
// checks a modbus rtu server response byte by byte and reports words and status
// ----------------------------------------------------------------------------
// The byte channel (byte_valid, byte_stall, rx_byte, frame_start) takes one
// response byte per item; frame_start marks byte 0 of a new response and drops
// any partial frame. The result channel (result_valid, result_stall and the
// result fields) gives a word item for each complete read register word of
// index 0 to 124 and one final status item per frame. Bytes after the final
// item are ignored until the next frame_start.
// An accepted byte is held in the input register; the crc-16 update and
// all frame checks run in one pass from there into the result register,
// which loads unless a waiting result is stalled. One byte per cycle is
// taken sustained while result_stall is low; crc_byte folds in a whole byte.
// A waiting result does not block input: one more byte is taken into the input
// register, and byte_stall rises only while both registers are full and
// result_stall is high.
// Reset clears the frame state, marks the frame closed and loads the register
// defaults (slave id 1, function 3, address 0, word 1).
// Configuration is written through cfg_we, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        is_final,
	output logic [6:0]  word_index,
	output logic [15:0] word_value,
	output logic [3:0]  status,
	output logic [7:0]  exception_code
);

	mrrc_pkg::cfg_t    cfg;
	mrrc_pkg::result_t result;
	logic              advance;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              start_s1;

	mrrc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
	end

	mrrc_frame_checker u_frame_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.valid_s1     (valid_s1),
		.byte_s1      (byte_s1),
		.start_s1     (start_s1),
		.result_stall (result_stall),
		.advance      (advance),
		.result_valid (result_valid),
		.result       (result)
	);

	assign is_final       = result.is_final;
	assign word_index     = result.word_index;
	assign word_value     = result.word_value;
	assign status         = 4'(result.status);
	assign exception_code = result.exception_code;

endmodule
